### src/ptvsl_pkg.sv
// Shared types and constants for the pan/tilt vector slew limiter.
// No dependencies; every other file in src imports this package.
package ptvsl_pkg;

    // Angle and arithmetic widths
    localparam int ANGLE_W    = 16;
    localparam int MAG_W      = 16;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int ROOT_W     = MAG_W + 1;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int SQ_REM_W   = ROOT_W + 1;
    localparam int MUL_CNT_W  = $clog2(MAG_W);
    localparam int SQRT_CNT_W = $clog2(ROOT_W);

    // Register widths
    localparam int LIMIT_W    = 15;
    localparam int SPEED_W    = 16;
    localparam int RATE_W     = 10;
    localparam int DB_W       = 10;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // Reset values
    localparam logic [LIMIT_W-1:0] PAN_LIMIT_RST  = LIMIT_W'(4500);
    localparam logic [LIMIT_W-1:0] TILT_LIMIT_RST = LIMIT_W'(3000);
    localparam logic [SPEED_W-1:0] SPEED_RST      = SPEED_W'(9000);
    localparam logic [RATE_W-1:0]  RATE_RST       = RATE_W'(20);
    localparam logic [DB_W-1:0]    DB_RST         = DB_W'(10);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PAN_LIMIT     = 3'd0,
        REG_TILT_LIMIT    = 3'd1,
        REG_DEFAULT_SPEED = 3'd2,
        REG_TICK_RATE     = 3'd3,
        REG_DEADBAND      = 3'd4
    } ptvsl_reg_t;

    typedef enum logic {
        OP_SET  = 1'b0,
        OP_TICK = 1'b1
    } ptvsl_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SQUARE,
        ST_ROOT,
        ST_DIVIDE,
        ST_UPDATE,
        ST_FINISH
    } ptvsl_state_t;

    typedef struct packed {
        ptvsl_op_t                 op;
        logic signed [ANGLE_W-1:0] pan_goal;
        logic signed [ANGLE_W-1:0] tilt_goal;
        logic [SPEED_W-1:0]        speed;
    } ptvsl_in_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] pan_now;
        logic signed [ANGLE_W-1:0] tilt_now;
        logic                      moved;
        logic                      settled;
    } ptvsl_out_t;

endpackage

### src/pan_tilt_vector_slew_limiter.sv
// Pan/tilt vector slew limiter: top level, sequencer and position state.
// Depends on ptvsl_pkg, ptvsl_mul, ptvsl_div and ptvsl_isqrt.
//
// Usage: items arrive on the s_ channel (valid/ready). A set-target item
// clamps the goal to the limit registers and stores the speed; a tick item
// moves the position one step towards the goal along the straight line.
// Every item yields exactly one transfer on the m_ channel with the current
// position and the moved / settled flags.
// Configuration registers are written on the cfg_ channel (index, data),
// which is always ready; write it only while the block is idle.
// A set-target item or a tick that finds the position within the deadband
// goes from the check state straight to the finishing state; a tick that
// snaps onto the goal skips the divide state. After the finishing state the
// sequencer is idle and can take the next input transfer.
// The long path is one item at a time through bit-serial units: multiply and
// speed/tick-rate divide, then square root, then divide.
// The input is taken again as soon as the sequencer is idle, even while a
// result sits unclaimed in the output register; a stalled receiver then
// holds the next result in the sequencer until the register frees up.
// Reset restores the register defaults, zeroes position and goal, speed 9000.
module pan_tilt_vector_slew_limiter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  ptvsl_pkg::ptvsl_in_t              s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ptvsl_pkg::ptvsl_out_t             m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ptvsl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [ptvsl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import ptvsl_pkg::*;

    function automatic logic [ANGLE_W-1:0] clamp_sym(
        input logic [ANGLE_W-1:0] v,
        input logic [LIMIT_W-1:0] lim
    );
        logic signed [ANGLE_W:0] vx;
        logic signed [ANGLE_W:0] hi;
        logic signed [ANGLE_W:0] lo;
        logic signed [ANGLE_W:0] r;
        vx = {v[ANGLE_W-1], v};
        hi = {2'b00, lim};
        lo = -hi;
        if (vx < lo) begin
            r = lo;
        end else if (vx > hi) begin
            r = hi;
        end else begin
            r = vx;
        end
        return r[ANGLE_W-1:0];
    endfunction

    // Configuration
    logic [LIMIT_W-1:0] pan_limit_reg, tilt_limit_reg;
    logic [SPEED_W-1:0] default_speed_reg;
    logic [RATE_W-1:0]  tick_rate_reg;
    logic [DB_W-1:0]    deadband_reg;

    // Position state
    logic [ANGLE_W-1:0] cur_pan_reg, cur_tilt_reg;
    logic [ANGLE_W-1:0] goal_pan_reg, goal_tilt_reg;
    logic [SPEED_W-1:0] active_speed_reg;

    ptvsl_state_t       state_reg, state_next;
    ptvsl_in_t          in_reg;
    logic [MAG_W-1:0]   step_reg;
    logic               snap_reg;
    logic               moved_reg;
    logic               m_valid_reg;
    ptvsl_out_t         m_data_reg;

    // Errors and flags
    logic signed [ANGLE_W:0] dp, dt;
    logic signed [ANGLE_W:0] neg_dp, neg_dt;
    logic [MAG_W-1:0]   mag_p, mag_t;
    logic               settled_now;
    logic [RATE_W-1:0]  rate_eff;

    // Unit handshakes and operands
    logic               mul_start, div_p_start, div_t_start, root_start;
    logic               mul_p_done, mul_t_done, div_p_done, div_t_done, root_done;
    logic [MAG_W-1:0]   mul_p_b, mul_t_b;
    logic [PROD_W-1:0]  mul_p_prod, mul_t_prod;
    logic [PROD_W-1:0]  div_p_dvd;
    logic [ROOT_W-1:0]  div_p_dsr;
    logic [MAG_W-1:0]   div_p_quot, div_t_quot;
    logic [RAD_W-1:0]   sum_sq;
    logic [ROOT_W-1:0]  root_len;

    logic               tick_run, sq_ready, root_ready, div_ready, snap, out_load;
    logic signed [ANGLE_W:0] delta_p, delta_t, sum_p, sum_t;
    logic [ANGLE_W-1:0] new_pan, new_tilt;

    always_comb begin
        dp     = {goal_pan_reg[ANGLE_W-1], goal_pan_reg} - {cur_pan_reg[ANGLE_W-1], cur_pan_reg};
        dt     = {goal_tilt_reg[ANGLE_W-1], goal_tilt_reg}
                 - {cur_tilt_reg[ANGLE_W-1], cur_tilt_reg};
        neg_dp = -dp;
        neg_dt = -dt;
        mag_p  = dp[ANGLE_W] ? neg_dp[MAG_W-1:0] : dp[MAG_W-1:0];
        mag_t  = dt[ANGLE_W] ? neg_dt[MAG_W-1:0] : dt[MAG_W-1:0];
        settled_now = (mag_p < MAG_W'(deadband_reg)) && (mag_t < MAG_W'(deadband_reg));
        rate_eff = (tick_rate_reg == '0) ? RATE_W'(1) : tick_rate_reg;
    end

    // Unit operands: squares and speed / tick rate first, then err * step and / length
    always_comb begin
        mul_p_b   = (state_reg == ST_CHECK) ? mag_p : div_p_quot;
        mul_t_b   = (state_reg == ST_CHECK) ? mag_t : div_p_quot;
        div_p_dvd = (state_reg == ST_CHECK) ? PROD_W'(active_speed_reg) : mul_p_prod;
        div_p_dsr = (state_reg == ST_CHECK) ? ROOT_W'(rate_eff) : root_len;
        sum_sq    = RAD_W'(mul_p_prod) + RAD_W'(mul_t_prod);
    end

    always_comb begin
        tick_run   = (in_reg.op == OP_TICK) && !settled_now;
        sq_ready   = mul_p_done && mul_t_done && div_p_done;
        root_ready = root_done && mul_p_done && mul_t_done;
        div_ready  = div_p_done && div_t_done;
        snap       = {1'b0, step_reg} >= root_len;
    end

    // Apply the step, truncating toward zero by sign-magnitude
    always_comb begin
        delta_p  = dp[ANGLE_W] ? -{1'b0, div_p_quot} : {1'b0, div_p_quot};
        delta_t  = dt[ANGLE_W] ? -{1'b0, div_t_quot} : {1'b0, div_t_quot};
        sum_p    = {cur_pan_reg[ANGLE_W-1], cur_pan_reg} + delta_p;
        sum_t    = {cur_tilt_reg[ANGLE_W-1], cur_tilt_reg} + delta_t;
        new_pan  = snap_reg ? goal_pan_reg  : sum_p[ANGLE_W-1:0];
        new_tilt = snap_reg ? goal_tilt_reg : sum_t[ANGLE_W-1:0];
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = tick_run ? ST_SQUARE : ST_FINISH;
            end
            ST_SQUARE: begin
                if (sq_ready) begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (root_ready) begin
                    state_next = snap ? ST_UPDATE : ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_ready) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready     = 1'b0;
        mul_start   = 1'b0;
        div_p_start = 1'b0;
        div_t_start = 1'b0;
        root_start  = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_CHECK: begin
                mul_start   = tick_run;
                div_p_start = tick_run;
            end
            ST_SQUARE: begin
                root_start = sq_ready;
                mul_start  = sq_ready;
            end
            ST_ROOT: begin
                div_p_start = root_ready && !snap;
                div_t_start = root_ready && !snap;
            end
            ST_DIVIDE, ST_UPDATE: begin
            end
            ST_FINISH: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pan_limit_reg     <= PAN_LIMIT_RST;
            tilt_limit_reg    <= TILT_LIMIT_RST;
            default_speed_reg <= SPEED_RST;
            tick_rate_reg     <= RATE_RST;
            deadband_reg      <= DB_RST;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_PAN_LIMIT:     pan_limit_reg     <= cfg_wdata[LIMIT_W-1:0];
                REG_TILT_LIMIT:    tilt_limit_reg    <= cfg_wdata[LIMIT_W-1:0];
                REG_DEFAULT_SPEED: default_speed_reg <= cfg_wdata[SPEED_W-1:0];
                REG_TICK_RATE:     tick_rate_reg     <= cfg_wdata[RATE_W-1:0];
                REG_DEADBAND:      deadband_reg      <= cfg_wdata[DB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // Position, goal and speed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_pan_reg      <= '0;
            cur_tilt_reg     <= '0;
            goal_pan_reg     <= '0;
            goal_tilt_reg    <= '0;
            active_speed_reg <= SPEED_RST;
            moved_reg        <= 1'b0;
        end else begin
            if (state_reg == ST_CHECK) begin
                moved_reg <= 1'b0;
                if (in_reg.op == OP_SET) begin
                    goal_pan_reg     <= clamp_sym(in_reg.pan_goal, pan_limit_reg);
                    goal_tilt_reg    <= clamp_sym(in_reg.tilt_goal, tilt_limit_reg);
                    active_speed_reg <= (in_reg.speed == '0) ? default_speed_reg
                                                             : in_reg.speed;
                end
            end
            if (state_reg == ST_UPDATE) begin
                cur_pan_reg  <= new_pan;
                cur_tilt_reg <= new_tilt;
                moved_reg    <= (new_pan != cur_pan_reg) || (new_tilt != cur_tilt_reg);
            end
        end
    end

    // Item and step holding registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (state_reg == ST_SQUARE && sq_ready) begin
            step_reg <= div_p_quot;
        end
        if (state_reg == ST_ROOT && root_ready) begin
            snap_reg <= snap;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.pan_now  <= cur_pan_reg;
            m_data_reg.tilt_now <= cur_tilt_reg;
            m_data_reg.moved    <= moved_reg;
            m_data_reg.settled  <= settled_now;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    ptvsl_mul u_mul_p (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mag_p),
        .mplier  (mul_p_b),
        .prod    (mul_p_prod),
        .done    (mul_p_done)
    );

    ptvsl_mul u_mul_t (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mag_t),
        .mplier  (mul_t_b),
        .prod    (mul_t_prod),
        .done    (mul_t_done)
    );

    ptvsl_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand (sum_sq),
        .root     (root_len),
        .done     (root_done)
    );

    ptvsl_div u_div_p (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_p_start),
        .dividend (div_p_dvd),
        .divisor  (div_p_dsr),
        .quot     (div_p_quot),
        .done     (div_p_done)
    );

    ptvsl_div u_div_t (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_t_start),
        .dividend (mul_t_prod),
        .divisor  (root_len),
        .quot     (div_t_quot),
        .done     (div_t_done)
    );

    // A result is only ever loaded from the finishing state
    a_load_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result transfer raised outside the finishing state");

    // The goal only changes while a set-target item is being applied
    a_goal_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_CHECK) |=> ($stable(goal_pan_reg) && $stable(goal_tilt_reg)))
        else $error("goal changed outside the check state");

    // The position only changes in the update state
    a_pos_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_UPDATE) |=> ($stable(cur_pan_reg) && $stable(cur_tilt_reg)))
        else $error("position changed outside the update state");

    // Never restart a serial unit that is still running
    a_mul_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> (mul_p_done && mul_t_done))
        else $error("multiplier restarted while busy");

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_p_start || div_t_start || root_start) |-> (div_p_done && div_t_done && root_done))
        else $error("divider or square root restarted while busy");

endmodule

### src/ptvsl_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on ptvsl_pkg.
module ptvsl_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ptvsl_pkg::MAG_W-1:0]   mcand,
    input  logic [ptvsl_pkg::MAG_W-1:0]   mplier,
    output logic [ptvsl_pkg::PROD_W-1:0]  prod,
    output logic                          done
);
    import ptvsl_pkg::*;

    logic [MAG_W-1:0]     mcand_reg;
    logic [PROD_W-1:0]    acc_reg, acc_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [MAG_W:0]       part;

    always_comb begin
        part = {1'b0, acc_reg[PROD_W-1:MAG_W]} + (acc_reg[0] ? {1'b0, mcand_reg} : '0);
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            acc_next  = {{MAG_W{1'b0}}, mplier};
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // add on the low bit, then shift the whole product right
            acc_next = {part, acc_reg[MAG_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MAG_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (start) begin
            mcand_reg <= mcand;
        end
    end

    assign prod = acc_reg;
    assign done = ~busy_reg;

endmodule

### src/ptvsl_div.sv
// Restoring divider, one quotient bit per cycle, MAG_W-bit quotient.
// Needs dividend below divisor * 2**MAG_W. Depends on ptvsl_pkg.
module ptvsl_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ptvsl_pkg::PROD_W-1:0]  dividend,
    input  logic [ptvsl_pkg::ROOT_W-1:0]  divisor,
    output logic [ptvsl_pkg::MAG_W-1:0]   quot,
    output logic                          done
);
    import ptvsl_pkg::*;

    logic [ROOT_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]    dsr_reg;
    logic [MAG_W-1:0]     q_reg, q_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [ROOT_W:0]      shifted;
    logic [ROOT_W:0]      diff;
    logic                 ge;

    always_comb begin
        shifted   = {rem_reg, q_reg[MAG_W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        ge        = shifted >= {1'b0, dsr_reg};
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = ROOT_W'(dividend[PROD_W-1:MAG_W]);
            q_next    = dividend[MAG_W-1:0];
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[ROOT_W-1:0] : shifted[ROOT_W-1:0];
            q_next   = {q_reg[MAG_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MAG_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (start) begin
            dsr_reg <= divisor;
        end
    end

    assign quot = q_reg;
    assign done = ~busy_reg;

endmodule

### src/ptvsl_isqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
// Root is the floor of the square root. Depends on ptvsl_pkg.
module ptvsl_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ptvsl_pkg::RAD_W-1:0]   radicand,
    output logic [ptvsl_pkg::ROOT_W-1:0]  root,
    output logic                          done
);
    import ptvsl_pkg::*;

    logic [RAD_W-1:0]      rad_reg, rad_next;
    logic [SQ_REM_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [SQRT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic [SQ_REM_W+1:0]   shifted;
    logic [SQ_REM_W+1:0]   trial;
    logic [SQ_REM_W+1:0]   diff;
    logic                  ge;

    always_comb begin
        shifted   = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        diff      = shifted - trial;
        ge        = shifted >= trial;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            rem_next  = ge ? diff[SQ_REM_W-1:0] : shifted[SQ_REM_W-1:0];
            root_next = {root_reg[ROOT_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == SQRT_CNT_W'(ROOT_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;
    assign done = ~busy_reg;

endmodule

### bench/tb_pan_tilt_vector_slew_limiter.sv
`timescale 1ns / 1ps
// Self-checking bench for pan_tilt_vector_slew_limiter: directed and random gaze moves
// checked against a scoreboard that predicts every result. Depends on ptvsl_pkg and the RTL.
module tb_pan_tilt_vector_slew_limiter;
    import ptvsl_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_STALL     = 400;
    localparam int SETTLE_CYCLES  = 100;

    typedef struct {
        logic [15:0] pan_limit;
        logic [15:0] tilt_limit;
        logic [15:0] default_speed;
        logic [15:0] tick_rate;
        logic [15:0] deadband;
    } gaze_settings_t;

    class gaze_scoreboard;
        logic [LIMIT_W-1:0] pan_limit, tilt_limit;
        logic [SPEED_W-1:0] default_speed;
        logic [RATE_W-1:0]  tick_rate;
        logic [DB_W-1:0]    deadband;
        int                 cur_pan, cur_tilt, goal_pan, goal_tilt;
        int unsigned        active_speed;
        ptvsl_out_t         expected_positions[$];
        int unsigned        mismatches;

        function new();
            pan_limit     = PAN_LIMIT_RST;
            tilt_limit    = TILT_LIMIT_RST;
            default_speed = SPEED_RST;
            tick_rate     = RATE_RST;
            deadband      = DB_RST;
            cur_pan       = 0;
            cur_tilt      = 0;
            goal_pan      = 0;
            goal_tilt     = 0;
            active_speed  = SPEED_RST;
            mismatches    = 0;
        endfunction

        function void write_reg(ptvsl_reg_t idx, logic [15:0] val);
            case (idx)
                REG_PAN_LIMIT:     pan_limit = val[LIMIT_W-1:0];
                REG_TILT_LIMIT:    tilt_limit = val[LIMIT_W-1:0];
                REG_DEFAULT_SPEED: default_speed = val;
                REG_TICK_RATE:     tick_rate = val[RATE_W-1:0];
                REG_DEADBAND:      deadband = val[DB_W-1:0];
                default:           ;
            endcase
        endfunction

        function int unsigned magnitude(int v);
            return v < 0 ? -v : v;
        endfunction

        function int wrap_angle(int v);
            logic signed [ANGLE_W-1:0] w;
            w = v[ANGLE_W-1:0];
            return w;
        endfunction

        function int clamp_goal(logic signed [ANGLE_W-1:0] v, logic [LIMIT_W-1:0] lim);
            int l = lim;
            int x = v;
            if (x < -l) return -l;
            if (x > l) return l;
            return x;
        endfunction

        // Build the root one bit at a time, keeping each bit whose square still fits
        function longint unsigned floor_root(longint unsigned x);
            longint unsigned r = 0;
            longint unsigned trial;
            for (int b = 20; b >= 0; b--) begin
                trial = r | (64'd1 << b);
                if (trial * trial <= x) r = trial;
            end
            return r;
        endfunction

        function bit is_settled();
            return magnitude(goal_pan - cur_pan) < deadband &&
                   magnitude(goal_tilt - cur_tilt) < deadband;
        endfunction

        function int share_of_step(int err, longint unsigned step, longint unsigned len);
            longint unsigned d = (magnitude(err) * step) / len;
            return err < 0 ? -int'(d) : int'(d);
        endfunction

        function void note_item(ptvsl_in_t it);
            ptvsl_out_t      res;
            int              dp, dt, np, nt;
            longint unsigned len, step;
            int unsigned     rate;
            bit              moved;
            moved = 1'b0;
            if (it.op == OP_SET) begin
                goal_pan     = wrap_angle(clamp_goal(it.pan_goal, pan_limit));
                goal_tilt    = wrap_angle(clamp_goal(it.tilt_goal, tilt_limit));
                active_speed = (it.speed == 0) ? default_speed : it.speed;
            end else if (!is_settled()) begin
                dp   = goal_pan - cur_pan;
                dt   = goal_tilt - cur_tilt;
                len  = floor_root(longint'(dp) * dp + longint'(dt) * dt);
                rate = (tick_rate == 0) ? 1 : tick_rate;
                step = active_speed / rate;
                if (step >= len) begin
                    np = goal_pan;
                    nt = goal_tilt;
                end else begin
                    np = wrap_angle(cur_pan + share_of_step(dp, step, len));
                    nt = wrap_angle(cur_tilt + share_of_step(dt, step, len));
                end
                moved    = (np != cur_pan) || (nt != cur_tilt);
                cur_pan  = np;
                cur_tilt = nt;
            end
            res.pan_now  = cur_pan[ANGLE_W-1:0];
            res.tilt_now = cur_tilt[ANGLE_W-1:0];
            res.moved    = moved;
            res.settled  = is_settled();
            expected_positions.push_back(res);
        endfunction

        function void compare_field(string name, logic signed [15:0] want,
                                    logic signed [15:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_position(ptvsl_out_t got);
            ptvsl_out_t want;
            if (expected_positions.size() == 0) begin
                $display("%0t: result with none pending: pan %0d tilt %0d moved %0b settled %0b",
                         $time, got.pan_now, got.tilt_now, got.moved, got.settled);
                mismatches++;
                return;
            end
            want = expected_positions.pop_front();
            compare_field("pan_now", want.pan_now, got.pan_now);
            compare_field("tilt_now", want.tilt_now, got.tilt_now);
            compare_field("moved", want.moved, got.moved);
            compare_field("settled", want.settled, got.settled);
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    ptvsl_in_t             s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    ptvsl_out_t            m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    gaze_scoreboard sb;
    int             tx_idle_pct = 0;
    int             rx_idle_pct = 0;
    int             stall_requests = 0;
    int             stalls_served = 0;
    int             hold_left = 0;
    int             quiet_cycles = 0;

    pan_tilt_vector_slew_limiter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    // Result side: check each transfer, then pick m_ready for the next cycle
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_position(m_data);
        if (stall_requests != stalls_served) begin
            stalls_served = stall_requests;
            hold_left = LONG_STALL;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

    task automatic send_item(input ptvsl_in_t it);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
    endtask

    task automatic send_set(input int pan, input int tilt, input int speed);
        ptvsl_in_t it;
        it.op        = OP_SET;
        it.pan_goal  = 16'(pan);
        it.tilt_goal = 16'(tilt);
        it.speed     = 16'(speed);
        send_item(it);
    endtask

    // Unused fields of a tick carry noise
    task automatic send_tick();
        ptvsl_in_t it;
        it.op        = OP_TICK;
        it.pan_goal  = 16'($urandom);
        it.tilt_goal = 16'($urandom);
        it.speed     = 16'($urandom);
        send_item(it);
    endtask

    task automatic cfg_transfer(input ptvsl_reg_t idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic load_settings(input gaze_settings_t cfg);
        cfg_transfer(REG_PAN_LIMIT, cfg.pan_limit);
        cfg_transfer(REG_TILT_LIMIT, cfg.tilt_limit);
        cfg_transfer(REG_DEFAULT_SPEED, cfg.default_speed);
        cfg_transfer(REG_TICK_RATE, cfg.tick_rate);
        cfg_transfer(REG_DEADBAND, cfg.deadband);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid and hold until every pending result has been taken
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (sb.expected_positions.size() != 0) @(posedge aclk);
    endtask

    function automatic int pick_angle(input int centre);
        int roll = $urandom_range(99);
        if (roll < 55) return int'($urandom_range(36000)) - 18000;
        if (roll < 80) return int'($urandom_range(65535)) - 32768;
        return centre + int'($urandom_range(40)) - 20;
    endfunction

    function automatic int pick_speed();
        int roll = $urandom_range(99);
        if (roll < 20) return 0;
        if (roll < 70) return $urandom_range(36000, 1);
        return $urandom_range(65535);
    endfunction

    task automatic run_random_phase(input int n_items);
        int        sent;
        int        run;
        ptvsl_in_t noise;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 85) begin
                // new goal, then a run of ticks towards it
                send_set(pick_angle(sb.cur_pan), pick_angle(sb.cur_tilt), pick_speed());
                run = ($urandom_range(3) == 0) ? $urandom_range(40, 10) : $urandom_range(8, 1);
                for (int i = 0; i < run; i++) send_tick();
                sent += run + 1;
            end else begin
                noise.op        = ptvsl_op_t'($urandom_range(1));
                noise.pan_goal  = 16'($urandom);
                noise.tilt_goal = 16'($urandom);
                noise.speed     = 16'($urandom);
                send_item(noise);
                sent++;
            end
        end
    endtask

    initial begin
        sb = new();
        tx_idle_pct = 8;
        rx_idle_pct = 82;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset settings, clamping, default speed, snap, deadband, tiny step
        send_tick();
        send_set(32767, -32768, 0);
        repeat (3) send_tick();
        send_set(-18000, 18000, 65535);
        repeat (4) send_tick();
        send_set(sb.cur_pan + 9, sb.cur_tilt - 9, 0);
        send_tick();
        send_set(100, -100, 19);
        send_tick();
        wait_for_results();

        // Zero tick rate, zero deadband, zero default speed, limits beyond range
        load_settings('{pan_limit: 16'hFFFF, tilt_limit: 16'h7FFF, default_speed: 16'd0,
                        tick_rate: 16'd0, deadband: 16'd0});
        send_set(sb.cur_pan, sb.cur_tilt, 0);
        send_tick();
        send_set(-32768, 32767, 0);
        send_tick();
        send_set(20000, -20000, 7);
        repeat (2) send_tick();
        wait_for_results();

        // Zero limits, widest register values
        load_settings('{pan_limit: 16'd0, tilt_limit: 16'd0, default_speed: 16'hFFFF,
                        tick_rate: 16'hFFFF, deadband: 16'hFFFF});
        send_set(5000, -5000, 0);
        repeat (2) send_tick();
        wait_for_results();

        load_settings('{pan_limit: 16'd18000, tilt_limit: 16'd18000, default_speed: 16'd9000,
                        tick_rate: 16'd20, deadband: 16'd10});
        run_random_phase(160);
        wait_for_results();

        tx_idle_pct = 82;
        rx_idle_pct = 8;
        load_settings('{pan_limit: 16'($urandom_range(18000, 1000)),
                        tilt_limit: 16'($urandom_range(18000, 1000)),
                        default_speed: 16'($urandom_range(36000, 1)),
                        tick_rate: 16'($urandom_range(100, 1)),
                        deadband: 16'($urandom_range(50))});
        run_random_phase(80);
        wait_for_results();
        run_random_phase(80);
        wait_for_results();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_settings('{pan_limit: 16'hFFFF, tilt_limit: 16'hFFFF, default_speed: 16'd36000,
                        tick_rate: 16'd5, deadband: 16'd0});
        stall_requests <= stall_requests + 1;
        run_random_phase(160);
        wait_for_results();

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.expected_positions.size() != 0)
            $display("%0t: %0d results never arrived", $time, sb.expected_positions.size());
        if (sb.mismatches == 0 && sb.expected_positions.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

### files.f
src/ptvsl_pkg.sv
src/ptvsl_mul.sv
src/ptvsl_div.sv
src/ptvsl_isqrt.sv
src/pan_tilt_vector_slew_limiter.sv
bench/tb_pan_tilt_vector_slew_limiter.sv
